[src/cfmq_pkg.sv]
package cfmq_pkg;

    // Queue geometry
    localparam int DEPTH = 1024;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2,
        MODE_MIN  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One finished result, handed from the controller to the output register
    typedef struct packed {
        logic                      valid;
        logic signed [WORD_W-1:0]  data;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } res_t;

    // Storage port command
    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } ram_cmd_t;

    // Ring pointer step; DEPTH need not be a power of two
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

endpackage

[src/cfmq_req_if.sv]
interface cfmq_req_if
    import cfmq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

[src/cfmq_rsp_if.sv]
interface cfmq_rsp_if
    import cfmq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;

    modport source (output valid, output data, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input is_empty, output ready);
endinterface

[src/cfmq_ram.sv]
module cfmq_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32,
    parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [WIDTH_P-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [WIDTH_P-1:0] rdata
);
    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[src/cfmq_ctrl.sv]
module cfmq_ctrl
    import cfmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    cfmq_req_if.sink                 req,
    input  logic                     res_free,
    output res_t                     res,
    output ram_cmd_t                 ram_cmd,
    input  logic signed [WORD_W-1:0] ram_rdata
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    mode_t                    op_reg, op_next;
    logic [PTR_W-1:0]         scan_ptr_reg, scan_ptr_next;
    logic [PTR_W-1:0]         left_reg, left_next;
    logic                     rvalid_reg, rvalid_next;
    logic                     first_reg, first_next;
    logic signed [WORD_W-1:0] min_reg, min_next;

    logic                     is_full;
    logic                     is_zero;
    logic [PTR_W-1:0]         tail_step;
    mode_t                    req_mode;

    assign is_full   = (count_reg == COUNT_W'(DEPTH));
    assign is_zero   = (count_reg == '0);
    assign tail_step = next_slot(tail_reg);
    assign req_mode  = mode_t'(req.mode);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        scan_ptr_next = scan_ptr_reg;
        left_next     = left_reg;
        rvalid_next   = rvalid_reg;
        first_next    = first_reg;
        min_next      = min_reg;

        req.ready     = 1'b0;

        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = tail_step;
        ram_cmd.wdata = req.value;
        ram_cmd.re    = 1'b0;
        ram_cmd.raddr = head_reg;

        res.valid     = 1'b0;
        res.data      = '0;
        res.status    = ST_OK;
        res.count     = count_reg;
        res.is_empty  = is_zero;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = res_free;
                if (req.valid && res_free)
                begin
                    if (req_mode == MODE_PUSH)
                    begin
                        res.valid = 1'b1;
                        if (is_full)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            ram_cmd.we   = 1'b1;
                            tail_next    = tail_step;
                            count_next   = count_reg + 1'b1;
                            res.count    = count_reg + 1'b1;
                            res.is_empty = 1'b0;
                        end
                    end
                    else if (is_zero)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        // first read of the oldest entry goes out now
                        ram_cmd.re    = 1'b1;
                        op_next       = req_mode;
                        rvalid_next   = 1'b1;
                        first_next    = 1'b1;
                        scan_ptr_next = next_slot(head_reg);
                        left_next     = PTR_W'(count_reg - 1'b1);
                        state_next    = (req_mode == MODE_MIN) ? S_SCAN : S_READ;
                    end
                end
            end

            S_READ:
            begin
                if (res_free)
                begin
                    res.valid = 1'b1;
                    res.data  = ram_rdata;
                    if (op_reg == MODE_POP)
                    begin
                        head_next    = next_slot(head_reg);
                        count_next   = count_reg - 1'b1;
                        res.count    = count_reg - 1'b1;
                        res.is_empty = (count_reg == COUNT_W'(1));
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (rvalid_reg)
                begin
                    first_next = 1'b0;
                    if (first_reg || (ram_rdata < min_reg))
                    begin
                        min_next = ram_rdata;
                    end
                end
                if (left_reg != '0)
                begin
                    ram_cmd.re    = 1'b1;
                    ram_cmd.raddr = scan_ptr_reg;
                    scan_ptr_next = next_slot(scan_ptr_reg);
                    left_next     = left_reg - 1'b1;
                    rvalid_next   = 1'b1;
                end
                else
                begin
                    // last entry is folded in this cycle
                    rvalid_next = 1'b0;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    res.valid  = 1'b1;
                    res.data   = min_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= PTR_W'(DEPTH - 1);
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        scan_ptr_reg <= scan_ptr_next;
        left_reg     <= left_next;
        min_reg      <= min_next;
    end
endmodule

[src/circular_fifo_with_min_query.sv]
// Results: push, and any request rejected as full or empty, shows on rsp the cycle after
//   acceptance; pop and peek first wait out the storage read, and a minimum reads every held word.
// One request at a time; pushes run one per cycle while each result is drained as it comes.
//   A held result stalls input unless drained that cycle.
// Reset: rst_n async active low empties the queue (head 0, tail DEPTH-1, count 0); storage
//   contents are not cleared and need no clearing pass.
module circular_fifo_with_min_query
    import cfmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cfmq_req_if.sink   req,
    cfmq_rsp_if.source rsp
);
    res_t                     res;
    ram_cmd_t                 ram_cmd;
    logic [WORD_W-1:0]        ram_rdata;
    logic                     res_free;

    // Output register, one result deep
    logic                     out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_data_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_empty_reg;

    // Slot is free when empty or being drained this cycle
    assign res_free = !out_valid_reg || rsp.ready;

    cfmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_free  (res_free),
        .res       (res),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata)
    );

    // Word storage, one write and one registered read port
    cfmq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; loads only with a new result
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_data_reg   <= res.data;
            out_status_reg <= res.status;
            out_count_reg  <= res.count;
            out_empty_reg  <= res.is_empty;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.data     = out_data_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.is_empty = out_empty_reg;
endmodule

[tb/circular_fifo_with_min_query_tb.sv]
`timescale 1ns / 100ps

module circular_fifo_with_min_query_tb;
    import cfmq_pkg::*;

    // Pattern sizes
    localparam int RANDOM_REQS = 1830;   // random requests after the directed part
    localparam int LONG_HOLD   = 400;    // cycles the response side holds off under pressure
    localparam int FULL_HITS   = 6;      // rejected pushes to see before draining

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Fields of one response as the block should present them
    typedef struct {
        logic signed [WORD_W-1:0] data;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
    } rsp_fields_t;

    // Shape of the random part: mixed traffic near empty, a fill to the
    // full limit with rejected pushes, then a drain back down
    typedef enum {PH_MIXED, PH_FILL, PH_DRAIN} phase_t;

    // Mirror of the queue contents plus the responses still owed by the block.
    // The minimum query only scans the mirror; contents stay in order.
    class min_queue_ledger;
        logic signed [WORD_W-1:0] held_words[$];
        rsp_fields_t              owed_rsps[$];
        int unsigned              fault_count;
        int unsigned              rsp_index;

        function new();
            fault_count = 0;
            rsp_index   = 0;
        endfunction

        function void flag(string what);
            fault_count++;
            if (fault_count <= 10)
                $display("[%0t] MISMATCH: %s", $time, what);
        endfunction

        // Called once per accepted request; works out the response it owes
        function void note_request(mode_t op, logic signed [WORD_W-1:0] word);
            rsp_fields_t e;
            e.data   = '0;
            e.status = ST_OK;
            if (op == MODE_PUSH) begin
                if (held_words.size() >= DEPTH)
                    e.status = ST_FULL;
                else
                    held_words.push_back(word);
            end
            else if (held_words.size() == 0) begin
                e.status = ST_EMPTY;
            end
            else begin
                case (op)
                    MODE_POP:  e.data = held_words.pop_front();
                    MODE_PEEK: e.data = held_words[0];
                    default:
                    begin
                        e.data = held_words[0];
                        foreach (held_words[i])
                            if (held_words[i] < e.data)
                                e.data = held_words[i];
                    end
                endcase
            end
            e.count    = COUNT_W'(held_words.size());
            e.is_empty = (held_words.size() == 0);
            owed_rsps.push_back(e);
        endfunction

        function void check_response(rsp_fields_t got);
            rsp_fields_t e;
            rsp_index++;
            if (owed_rsps.size() == 0) begin
                flag($sformatf("response %0d with nothing owed: data %0d status %0d count %0d",
                               rsp_index, got.data, got.status, got.count));
                return;
            end
            e = owed_rsps.pop_front();
            if (got.data !== e.data || got.status !== e.status ||
                got.count !== e.count || got.is_empty !== e.is_empty)
                flag($sformatf({"response %0d exp/got: data %0d/%0d status %0d/%0d ",
                                "count %0d/%0d empty %0b/%0b"},
                               rsp_index, e.data, got.data, e.status, got.status,
                               e.count, got.count, e.is_empty, got.is_empty));
        endfunction

        function void close_out();
            if (owed_rsps.size() != 0)
                flag($sformatf("%0d responses never arrived", owed_rsps.size()));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cfmq_req_if req_bus ();
    cfmq_rsp_if rsp_bus ();

    circular_fifo_with_min_query u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source)
    );

    min_queue_ledger ledger = new();

    // Set by the request side, picked up by the response side: asks for one long hold-off
    bit          hold_off_pending = 1'b0;
    // Remaining requests sent back to back with no idle cycles
    int unsigned send_steady      = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic mode_t pick_mode(input int unsigned w_push, input int unsigned w_pop,
                                        input int unsigned w_peek, input int unsigned w_min);
        int unsigned r;
        r = $urandom_range(0, w_push + w_pop + w_peek + w_min - 1);
        if (r < w_push)
            return MODE_PUSH;
        if (r < w_push + w_pop)
            return MODE_POP;
        if (r < w_push + w_pop + w_peek)
            return MODE_PEEK;
        return MODE_MIN;
    endfunction

    // Payload words lean on the signed extremes so the minimum sees them often
    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one request and returns at the edge where it is taken.
    // Called in the step of the previous acceptance, so valid either stays
    // high (one assignment) or drops for a gap carrying junk payload.
    task automatic send_request(input mode_t op, input logic signed [WORD_W-1:0] word);
        int unsigned gap;
        if (send_steady > 0)
        begin
            send_steady--;
            gap = 0;
        end
        else
        begin
            gap = idle_length();
            if ($urandom_range(0, 99) < 3)
                send_steady = $urandom_range(30, 150);
        end
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap)
            begin
                req_bus.mode  <= MODE_W'($urandom());
                req_bus.value <= $urandom();
                @(posedge clk);
            end
        end
        req_bus.valid <= 1'b1;
        req_bus.mode  <= op;
        req_bus.value <= word;
        // ready is sampled before this edge's updates land
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        ledger.note_request(op, word);
    endtask

    // Response side: checks every accepted response and throttles ready.
    // A long hold-off is counted here so the request side keeps offering
    // and the block backs up into its input.
    initial
    begin : response_side
        int unsigned stall_left;
        int unsigned steady_left;
        rsp_fields_t got;
        stall_left  = 0;
        steady_left = 0;
        rsp_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                got.data     = rsp_bus.data;
                got.status   = status_t'(rsp_bus.status);
                got.count    = rsp_bus.count;
                got.is_empty = rsp_bus.is_empty;
                ledger.check_response(got);
            end
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0)
            begin
                if (steady_left > 0)
                    steady_left--;
                else if ($urandom_range(0, 99) < 3)
                    steady_left = $urandom_range(30, 150);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = idle_length();
            end
            if (stall_left > 0)
            begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // Request side: reset, directed requests, shaped random traffic, drain
    initial
    begin : request_side
        phase_t      phase;
        int unsigned full_hits;
        mode_t       op;

        rst_n = 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.mode  <= MODE_PUSH;
        req_bus.value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Empty errors straight out of reset
        send_request(MODE_POP,  random_word());
        send_request(MODE_PEEK, random_word());
        send_request(MODE_MIN,  random_word());

        // Single entry: peek and minimum both see it
        send_request(MODE_PUSH, WORD_MAX);
        send_request(MODE_PEEK, random_word());
        send_request(MODE_MIN,  random_word());

        // Signed extremes around zero; minimum must pick the most negative
        send_request(MODE_PUSH, WORD_MIN);
        send_request(MODE_PUSH, '0);
        send_request(MODE_PUSH, '1);
        send_request(MODE_PUSH, 1);
        send_request(MODE_MIN,  random_word());

        // Pops come out oldest first; the minimum follows what is left
        send_request(MODE_POP,  random_word());
        send_request(MODE_POP,  random_word());
        send_request(MODE_MIN,  random_word());
        send_request(MODE_PEEK, random_word());
        send_request(MODE_PUSH, -7);
        send_request(MODE_MIN,  random_word());

        // Drain to empty and hit the empty errors again
        send_request(MODE_POP,  random_word());
        send_request(MODE_POP,  random_word());
        send_request(MODE_POP,  random_word());
        send_request(MODE_POP,  random_word());
        send_request(MODE_POP,  random_word());
        send_request(MODE_MIN,  random_word());
        send_request(MODE_PEEK, random_word());

        // Random part. The mixed stretch wanders near empty; the fill walks
        // the ring past its wrap point up to the full limit, where pushes are
        // rejected and full-length minimum scans run; then it drains.
        phase     = PH_MIXED;
        full_hits = 0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 150 || n == 1000)
                hold_off_pending = 1'b1;
            case (phase)
                PH_MIXED:
                begin
                    op = pick_mode(35, 30, 15, 20);
                    if (n >= 250)
                        phase = PH_FILL;
                end
                PH_FILL:
                begin
                    if (ledger.held_words.size() < DEPTH)
                    begin
                        op = pick_mode(94, 2, 2, 2);
                    end
                    else
                    begin
                        op = pick_mode(50, 0, 20, 30);
                        if (op == MODE_PUSH)
                            full_hits++;
                        if (full_hits >= FULL_HITS)
                            phase = PH_DRAIN;
                    end
                end
                default:
                begin
                    op = pick_mode(8, 80, 6, 6);
                    if (ledger.held_words.size() == 0)
                        phase = PH_MIXED;
                end
            endcase
            send_request(op, random_word());
        end
        req_bus.valid <= 1'b0;

        // Wait for every owed response, then watch a while for strays
        while (ledger.owed_rsps.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 16) @(posedge clk);
        ledger.close_out();

        if (ledger.fault_count == 0)
            $display("circular_fifo_with_min_query verification clean");
        else
            $display("circular_fifo_with_min_query verification failed");
        $finish;
    end

    // Watchdog: well beyond a run where every request is a full scan behind long stalls
    initial
    begin
        #50_000_000;
        $display("circular_fifo_with_min_query verification failed");
        $finish;
    end

endmodule
